// File: design/asgc_pkg.sv
// Shared types and constants for the actuated signal gap controller.
package asgc_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_UPDATE = 2'd1;
    localparam logic [1:0] FUNC_SWITCH = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_GAP     = 2'd0;
    localparam logic [1:0] CFG_DET_GAP     = 2'd1;
    localparam logic [1:0] CFG_PHASE_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [15:0] MAX_GAP_RST     = 16'd3000;
    localparam logic [15:0] DET_GAP_RST     = 16'd2000;
    localparam logic [4:0]  PHASE_COUNT_RST = 5'd1;

    // Detector gap value meaning no detection
    localparam logic [15:0] GAP_NONE = 16'hFFFF;

    // Index field and mask field limit how many entries are reachable
    localparam int IDX_SPAN = 16;

    // Milliseconds per second and the widths of the remainder unit operand and result
    localparam int          MS_PER_SEC = 1000;
    localparam int          MOD_W      = 25;
    localparam int          REM_W      = 10;

    // One phase table entry
    typedef struct packed {
        logic [23:0] min_ms;
        logic [23:0] max_ms;
        logic        green;
        logic [15:0] mask;
    } phase_entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DECIDE,
        S_TOTAL,
        S_MOD_E,
        S_MOD_T,
        S_ROUND,
        S_ADV,
        S_FETCH,
        S_DONE
    } seq_state_t;

endpackage

// File: design/asgc_sec_mod.sv
// Remainder by one second (1000 ms) through a reciprocal multiply.
module asgc_sec_mod
    import asgc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MOD_W-1:0] dividend,
    output logic             done,
    output logic [REM_W-1:0] remainder
);

    // floor(x / 1000) equals (x * RECIP) >> SHIFT for every x below 2**MOD_W
    localparam int SHIFT = MOD_W + REM_W;
    localparam int RCP_W = MOD_W + 1;
    localparam int MUL_W = MOD_W + RCP_W;
    localparam int Q_W   = MUL_W - SHIFT;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) / 64'(MS_PER_SEC)) + 64'd1);

    logic [MOD_W-1:0] x_reg;
    logic [Q_W-1:0]   q_reg;
    logic [REM_W-1:0] rem_reg;
    logic [2:0]       stage_reg;
    logic [Q_W-1:0]   q_next;
    logic [MOD_W-1:0] back;
    logic [REM_W-1:0] rem_next;

    // Quotient estimate, then the remainder from the quotient
    always_comb
    begin
        q_next   = Q_W'((MUL_W'(x_reg) * MUL_W'(RECIP)) >> SHIFT);
        back     = MOD_W'(q_reg) * MOD_W'(MS_PER_SEC);
        rem_next = REM_W'(x_reg - back);
    end

    assign done      = stage_reg[2];
    assign remainder = rem_reg;

    // Stage flags: multiply, subtract, result ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dividend;
        end
        if (stage_reg[0])
        begin
            q_reg <= q_next;
        end
        if (stage_reg[1])
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// File: design/actuated_signal_gap_control.sv
// Top level of the actuated signal phase sequencer with gap-out control.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    func, index, min_dur_ms, max_dur_ms, green,
//                                           detector_mask, gap_ms, now_ms
// out       output     out_valid/out_ready  next_duration_ms, phase, extended
// cfg       input      cfg_write            cfg_index, cfg_data
//
// Load, detector update and unused items are taken while idle and leave the sequencer
// idle. A switch request fetches its entry, scans D = min(NUM_DETECTORS, 16) detector
// gaps and decides, then either advances the phase or extends it: the extension is
// rounded by a reciprocal-multiply remainder unit run once on the extension and once
// on the total.
// Reset clears control state and sets detector gaps to no detection; the phase table
// holds nothing until loaded. A stalled output holds the finished item in the output
// register while loads and updates go on; a switch request waits in its last state.
module actuated_signal_gap_control
    import asgc_pkg::*;
#(
    parameter int MAX_PHASES    = 16,
    parameter int NUM_DETECTORS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  index,
    input  logic [23:0] min_dur_ms,
    input  logic [23:0] max_dur_ms,
    input  logic        green,
    input  logic [15:0] detector_mask,
    input  logic [15:0] gap_ms,
    input  logic [31:0] now_ms,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] next_duration_ms,
    output logic [3:0]  phase,
    output logic        extended,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Only the first sixteen entries are reachable through the index field
    localparam int PT_DEPTH = (MAX_PHASES < IDX_SPAN) ? MAX_PHASES : IDX_SPAN;
    localparam int ND_EFF   = (NUM_DETECTORS < IDX_SPAN) ? NUM_DETECTORS : IDX_SPAN;
    localparam int PAW      = $clog2(PT_DEPTH);
    localparam int DCW      = (ND_EFF > 1) ? $clog2(ND_EFF) : 1;
    localparam int PH_W     = $clog2(MAX_PHASES);
    localparam logic [DCW-1:0] DET_LAST = DCW'(ND_EFF - 1);
    localparam logic [6:0]     PH_MAX7  = 7'(MAX_PHASES);

    seq_state_t state_reg, state_next;

    // Configuration registers
    logic [15:0] max_gap_reg;
    logic [15:0] det_gap_reg;
    logic [4:0]  phase_count_reg;

    // Sequencer state
    logic [PH_W-1:0]  cur_reg;
    logic [31:0]      start_reg;
    logic [31:0]      now_reg;
    logic [31:0]      elapsed_reg;
    logic [DCW-1:0]   det_cnt_reg;
    logic             found_reg;
    logic [15:0]      best_reg;
    logic [23:0]      e_reg;
    logic [MOD_W-1:0] total_reg;
    logic [REM_W-1:0] rem_e_reg;
    logic [MOD_W-1:0] e_rnd_reg;
    logic [23:0]      res_dur_reg;
    logic             res_ext_reg;

    // Output register
    logic        out_valid_reg;
    logic [23:0] out_dur_reg;
    logic [3:0]  out_phase_reg;
    logic        out_ext_reg;

    // Phase table and detector gaps
    phase_entry_t phase_mem [PT_DEPTH];
    phase_entry_t rd_reg;
    logic [15:0]  gap_reg [ND_EFF];

    logic in_acc;
    logic out_free;

    // Remainder unit
    logic             mod_start;
    logic [MOD_W-1:0] mod_in;
    logic             mod_done;
    logic [REM_W-1:0] mod_rem;

    asgc_sec_mod u_sec_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_in),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg     <= MAX_GAP_RST;
            det_gap_reg     <= DET_GAP_RST;
            phase_count_reg <= PHASE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_GAP:     max_gap_reg     <= cfg_data;
                CFG_DET_GAP:     det_gap_reg     <= cfg_data;
                CFG_PHASE_COUNT: phase_count_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // Phase table: written by load items, read at the current phase
    always_ff @(posedge clk)
    begin
        if (in_acc && (func == FUNC_LOAD) && (32'(index) < 32'(PT_DEPTH)))
        begin
            phase_mem[index[PAW-1:0]] <= '{min_ms: min_dur_ms, max_ms: max_dur_ms,
                                           green: green, mask: detector_mask};
        end
        rd_reg <= phase_mem[cur_reg[PAW-1:0]];
    end

    // Detector gaps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ND_EFF; i++)
            begin
                gap_reg[i] <= GAP_NONE;
            end
        end
        else if (in_acc && (func == FUNC_UPDATE) && (32'(index) < 32'(ND_EFF)))
        begin
            gap_reg[index[DCW-1:0]] <= gap_ms;
        end
    end

    // Scan step: one detector per cycle
    logic [15:0] scan_gap;
    logic        scan_hit;

    always_comb
    begin
        scan_gap = gap_reg[det_cnt_reg];
        scan_hit = rd_reg.mask[4'(det_cnt_reg)] && (scan_gap < max_gap_reg);
    end

    // Keep decision and raw extension
    logic               keep;
    logic [23:0]        el24;
    logic signed [25:0] e_min;
    logic signed [25:0] e_gap;
    logic signed [25:0] e_sel;
    logic [23:0]        e_val;

    always_comb
    begin
        el24  = elapsed_reg[23:0];
        keep  = rd_reg.green && (elapsed_reg < {8'b0, rd_reg.max_ms}) && found_reg;
        e_min = $signed({2'b0, rd_reg.min_ms}) - $signed({2'b0, el24});
        e_gap = $signed({10'b0, det_gap_reg}) - $signed({10'b0, best_reg});
        e_sel = (e_gap > e_min) ? e_gap : e_min;
        if (e_sel < 26'sd1)
        begin
            e_sel = 26'sd1;
        end
        e_val = e_sel[23:0];
    end

    // Whole-second rounding and cap
    logic [MOD_W-1:0] e_rnd;
    logic [23:0]      cap;
    logic [23:0]      e_capped;

    always_comb
    begin
        if (rem_e_reg != '0)
        begin
            e_rnd = {1'b0, e_reg} + MOD_W'(MS_PER_SEC) - MOD_W'(mod_rem);
        end
        else
        begin
            e_rnd = {1'b0, e_reg};
        end
        cap = rd_reg.max_ms - el24;
        if (e_rnd_reg < {1'b0, cap})
        begin
            e_capped = e_rnd_reg[23:0];
        end
        else
        begin
            e_capped = cap;
        end
    end

    // Phase advance with wrap
    logic [6:0]      count_eff;
    logic [6:0]      cur_inc;
    logic [PH_W-1:0] cur_adv;

    always_comb
    begin
        count_eff = 7'(phase_count_reg);
        if (count_eff == 7'd0)
        begin
            count_eff = 7'd1;
        end
        else if (count_eff > PH_MAX7)
        begin
            count_eff = PH_MAX7;
        end
        cur_inc = 7'(cur_reg) + 7'd1;
        cur_adv = (cur_inc >= count_eff) ? '0 : PH_W'(cur_inc);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (func == FUNC_SWITCH))
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (det_cnt_reg == DET_LAST)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = keep ? S_TOTAL : S_ADV;
            S_TOTAL:  state_next = S_MOD_E;
            S_MOD_E:
            begin
                if (mod_done)
                begin
                    state_next = S_MOD_T;
                end
            end
            S_MOD_T:
            begin
                if (mod_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:  state_next = S_DONE;
            S_ADV:    state_next = S_FETCH;
            S_FETCH:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mod_start = 1'b0;
        mod_in    = total_reg;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_TOTAL:
            begin
                mod_start = 1'b1;
                mod_in    = {1'b0, e_reg};
            end
            S_MOD_E: mod_start = mod_done;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ADV)
            begin
                cur_reg   <= cur_adv;
                start_reg <= now_reg;
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                now_reg <= now_ms;
            end
            S_LOAD:
            begin
                elapsed_reg <= now_reg - start_reg;
                det_cnt_reg <= '0;
                found_reg   <= 1'b0;
                best_reg    <= GAP_NONE;
            end
            S_SCAN:
            begin
                if (scan_hit && (!found_reg || (scan_gap < best_reg)))
                begin
                    best_reg <= scan_gap;
                end
                if (scan_hit)
                begin
                    found_reg <= 1'b1;
                end
                det_cnt_reg <= det_cnt_reg + 1'b1;
            end
            S_DECIDE:
            begin
                e_reg <= e_val;
            end
            S_TOTAL:
            begin
                total_reg <= {1'b0, e_reg} + {1'b0, el24};
            end
            S_MOD_E:
            begin
                if (mod_done)
                begin
                    rem_e_reg <= mod_rem;
                end
            end
            S_MOD_T:
            begin
                if (mod_done)
                begin
                    e_rnd_reg <= e_rnd;
                end
            end
            S_ROUND:
            begin
                res_dur_reg <= e_capped;
                res_ext_reg <= 1'b1;
            end
            S_ADV:
            begin
                res_ext_reg <= 1'b0;
            end
            default: ;
        endcase

        // Load the output register once the slot is free
        if ((state_reg == S_DONE) && out_free)
        begin
            out_phase_reg <= 4'(cur_reg);
            out_ext_reg   <= res_ext_reg;
            if (res_ext_reg)
            begin
                out_dur_reg <= res_dur_reg;
            end
            else if (rd_reg.min_ms == 24'd0)
            begin
                out_dur_reg <= 24'd1;
            end
            else
            begin
                out_dur_reg <= rd_reg.min_ms;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign next_duration_ms = out_dur_reg;
    assign phase            = out_phase_reg;
    assign extended         = out_ext_reg;

endmodule

// File: tb/actuated_signal_gap_control_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the actuated signal gap-out sequencer.
module actuated_signal_gap_control_tb;
    import asgc_pkg::*;

    localparam logic [1:0] FUNC_NONE     = 2'd3;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         IDLE_MAX      = 12;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SWEEP_ITEMS   = 55;

    // One input item as driven on the ports
    typedef struct {
        logic [1:0]  func;
        logic [3:0]  index;
        logic [23:0] min_dur_ms;
        logic [23:0] max_dur_ms;
        logic        green;
        logic [15:0] detector_mask;
        logic [15:0] gap_ms;
        logic [31:0] now_ms;
    } signal_item_t;

    // One timing decision returned by the block
    typedef struct {
        logic [23:0] duration;
        logic [3:0]  phase;
        logic        extended;
    } timing_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [3:0]  index;
    logic [23:0] min_dur_ms;
    logic [23:0] max_dur_ms;
    logic        green;
    logic [15:0] detector_mask;
    logic [15:0] gap_ms;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] next_duration_ms;
    logic [3:0]  phase;
    logic        extended;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Signal plan mirrored on this side
    phase_entry_t phase_plan [16];
    logic [15:0]  detector_age [16];
    logic [3:0]   active_phase;
    logic [31:0]  phase_begin_ms;
    logic [15:0]  gap_limit_ms;
    logic [15:0]  travel_ms;
    logic [4:0]   phases_in_use;

    timing_t pending_timings [$];

    int errors;
    int cycle_count;
    int items_accepted;
    int switches_sent;
    int extensions;
    int advances;
    int regs_written;
    int results_seen;
    bit src_idle;
    bit snk_idle;
    int sink_wait;
    int stall_hold;

    actuated_signal_gap_control dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .func             (func),
        .index            (index),
        .min_dur_ms       (min_dur_ms),
        .max_dur_ms       (max_dur_ms),
        .green            (green),
        .detector_mask    (detector_mask),
        .gap_ms           (gap_ms),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .next_duration_ms (next_duration_ms),
        .phase            (phase),
        .extended         (extended),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_timings.size());
        $display("actuated_signal_gap_control_tb: errors");
        $finish;
    end

    // Mirror of the sequencer: updates state and queues the expected timing
    task automatic step_signal_plan(input signal_item_t it);
        timing_t     t;
        logic [31:0] elapsed;
        logic [15:0] best;
        bit          found;
        longint      el;
        longint      ext;
        longint      travel;
        longint      cap;
        int          span;
        int          nxt;
        case (it.func)
            FUNC_LOAD:
            begin
                phase_plan[it.index] = '{it.min_dur_ms, it.max_dur_ms, it.green,
                                         it.detector_mask};
            end
            FUNC_UPDATE:
            begin
                detector_age[it.index] = it.gap_ms;
            end
            FUNC_SWITCH:
            begin
                switches_sent++;
                elapsed = it.now_ms - phase_begin_ms;
                found = 1'b0;
                best = GAP_NONE;
                // smallest recent gap among the phase's detectors
                for (int d = 0; d < 16; d++)
                begin
                    if (phase_plan[active_phase].mask[d] && detector_age[d] < gap_limit_ms)
                    begin
                        if (!found || detector_age[d] < best)
                            best = detector_age[d];
                        found = 1'b1;
                    end
                end
                if (phase_plan[active_phase].green && found &&
                    elapsed < {8'd0, phase_plan[active_phase].max_ms})
                begin
                    // keep green: uneven extension ends on whole second, capped at max
                    el = longint'(elapsed);
                    ext = longint'(phase_plan[active_phase].min_ms) - el;
                    travel = longint'(travel_ms) - longint'(best);
                    cap = longint'(phase_plan[active_phase].max_ms) - el;
                    if (travel > ext)
                        ext = travel;
                    if (ext < 1)
                        ext = 1;
                    if (ext % MS_PER_SEC != 0)
                        ext = ((ext + el) / MS_PER_SEC + 1) * MS_PER_SEC - el;
                    if (ext > cap)
                        ext = cap;
                    t.duration = ext[23:0];
                    t.phase = active_phase;
                    t.extended = 1'b1;
                    extensions++;
                end
                else
                begin
                    // advance with wrap at the clamped phase count
                    span = (phases_in_use == 0) ? 1 : (phases_in_use > 16) ? 16 : phases_in_use;
                    nxt = int'(active_phase) + 1;
                    if (nxt >= span)
                        nxt = 0;
                    active_phase = nxt[3:0];
                    phase_begin_ms = it.now_ms;
                    t.duration = (phase_plan[active_phase].min_ms == 0) ? 24'd1 :
                                 phase_plan[active_phase].min_ms;
                    t.phase = active_phase;
                    t.extended = 1'b0;
                    advances++;
                end
                pending_timings.push_back(t);
            end
            default:
            begin
            end
        endcase
    endtask

    // Every field random, so unused fields still toggle
    function automatic signal_item_t noise_item();
        signal_item_t it;
        it.func = FUNC_NONE;
        it.index = 4'($urandom);
        it.min_dur_ms = 24'($urandom);
        it.max_dur_ms = 24'($urandom);
        it.green = 1'($urandom);
        it.detector_mask = 16'($urandom);
        it.gap_ms = 16'($urandom);
        it.now_ms = $urandom;
        return it;
    endfunction

    function automatic signal_item_t load_item(input logic [3:0] idx, input logic [23:0] lo,
                                               input logic [23:0] hi, input logic grn,
                                               input logic [15:0] mask);
        signal_item_t it;
        it = noise_item();
        it.func = FUNC_LOAD;
        it.index = idx;
        it.min_dur_ms = lo;
        it.max_dur_ms = hi;
        it.green = grn;
        it.detector_mask = mask;
        return it;
    endfunction

    function automatic signal_item_t gap_item(input logic [3:0] idx, input logic [15:0] gap);
        signal_item_t it;
        it = noise_item();
        it.func = FUNC_UPDATE;
        it.index = idx;
        it.gap_ms = gap;
        return it;
    endfunction

    function automatic signal_item_t switch_item(input logic [31:0] now);
        signal_item_t it;
        it = noise_item();
        it.func = FUNC_SWITCH;
        it.now_ms = now;
        return it;
    endfunction

    // Switch request timed mostly within the active phase's window
    function automatic signal_item_t paced_switch();
        if ($urandom_range(0, 4) != 0)
            return switch_item(phase_begin_ms +
                               $urandom_range(0, phase_plan[active_phase].max_ms + 3000));
        return switch_item($urandom);
    endfunction

    // Mostly well-formed traffic with random content, some noise
    function automatic signal_item_t random_item();
        signal_item_t it;
        int           pick;
        logic [23:0]  lo;
        logic [15:0]  gap;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            if ($urandom_range(0, 6) != 0)
            begin
                lo = 24'($urandom_range(0, 15000));
                it = load_item(4'($urandom), lo, 24'(lo + $urandom_range(0, 40000)),
                               $urandom_range(0, 3) != 0, 16'($urandom));
            end
            else
            begin
                it = noise_item();
                it.func = FUNC_LOAD;
            end
        end
        else if (pick < 40)
        begin
            case ($urandom_range(0, 6))
                0: gap = GAP_NONE;
                1: gap = 16'($urandom);
                default: gap = 16'($urandom_range(0, 6000));
            endcase
            it = gap_item(4'($urandom), gap);
        end
        else if (pick < 95)
        begin
            it = paced_switch();
        end
        else
        begin
            it = noise_item();
        end
        return it;
    endfunction

    // Offer one item, wait for acceptance, predict; returns at a falling edge
    task automatic offer_item(input signal_item_t it);
        int gap;
        gap = src_idle ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func = it.func;
        index = it.index;
        min_dur_ms = it.min_dur_ms;
        max_dur_ms = it.max_dur_ms;
        green = it.green;
        detector_mask = it.detector_mask;
        gap_ms = it.gap_ms;
        now_ms = it.now_ms;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_accepted++;
        step_signal_plan(it);
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain();
        in_valid = 1'b0;
        while (pending_timings.size() != 0)
            @(negedge clk);
    endtask

    // Idle point: results back and any trailing load or update finished
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            CFG_MAX_GAP:     gap_limit_ms = data;
            CFG_DET_GAP:     travel_ms = data;
            CFG_PHASE_COUNT: phases_in_use = data[4:0];
            default:
            begin
            end
        endcase
        regs_written++;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Fill every phase entry, extremes first
    task automatic test_table_load();
        for (int i = 0; i < 16; i++)
        begin
            case (i)
                0: offer_item(load_item(4'(i), 24'd0, 24'hFFFFFF, 1'b1, 16'hFFFF));
                1: offer_item(load_item(4'(i), 24'hFFFFFF, 24'd0, 1'b0, 16'h0000));
                2: offer_item(load_item(4'(i), 24'd0, 24'd5000, 1'b1, 16'h0004));
                3: offer_item(load_item(4'(i), 24'd1000, 24'd1500, 1'b1, 16'h0004));
                default: offer_item(load_item(4'(i), 24'(1000 * i), 24'(1000 * i + 30000),
                                              i[0], 16'($urandom)));
            endcase
        end
    endtask

    // Rounding, capping, wrap of elapsed time and of the phase count
    task automatic test_special_cases();
        signal_item_t it;
        settle();
        write_reg(CFG_PHASE_COUNT, 16'd4);
        it = noise_item();
        it.func = FUNC_NONE;
        offer_item(it);
        offer_item(gap_item(4'd0, 16'd0));
        offer_item(switch_item(32'd500));
        offer_item(gap_item(4'd0, 16'd1500));
        offer_item(switch_item(32'd1234));
        offer_item(gap_item(4'd0, GAP_NONE));
        offer_item(switch_item(32'd3000));
        offer_item(switch_item(32'd3001));
        offer_item(gap_item(4'd2, 16'd100));
        // request earlier than the phase start
        offer_item(switch_item(32'd3000));
        offer_item(switch_item(32'd4400));
        settle();
        // shrink the count below the active phase
        write_reg(CFG_PHASE_COUNT, 16'd2);
        offer_item(switch_item(32'd4500));
        offer_item(gap_item(4'd2, GAP_NONE));
        offer_item(gap_item(4'd0, 16'd1999));
        offer_item(switch_item(32'd4500));
    endtask

    // Random traffic under a series of register settings
    task automatic test_random_settings();
        logic [15:0] gap_limits [7];
        logic [15:0] travels [7];
        logic [15:0] counts [7];
        gap_limits = '{16'd3000, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd12000, 16'd2500};
        travels = '{16'd2000, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd8000, 16'd6000};
        counts = '{16'd8, 16'd16, 16'd0, 16'd31, 16'd17, 16'hFFE3, 16'd3};
        gap_limits[4] = 16'($urandom);
        travels[4] = 16'($urandom);
        for (int s = 0; s < 7; s++)
        begin
            settle();
            write_reg(CFG_MAX_GAP, gap_limits[s]);
            write_reg(CFG_DET_GAP, travels[s]);
            write_reg(CFG_PHASE_COUNT, counts[s]);
            src_idle = (s != 1);
            snk_idle = (s != 1) && (s != 3);
            repeat (SWEEP_ITEMS) offer_item(random_item());
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // Receiver holds off while switch requests keep coming
    task automatic test_output_stall();
        in_valid = 1'b0;
        @(posedge clk);
        stall_hold = HOLD_CYCLES;
        @(negedge clk);
        repeat (14) offer_item(paced_switch());
    endtask

    // Sender stops until all results are in, then resumes
    task automatic test_sender_pause();
        repeat (20) offer_item(random_item());
        drain();
        repeat (20) offer_item(random_item());
    endtask

    // Receiver: random stalls per result plus an occasional long hold
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                out_ready = 1'b0;
                stall_hold--;
            end
            else if (sink_wait > 0)
            begin
                out_ready = 1'b0;
                sink_wait--;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        timing_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_timings.size() == 0)
            begin
                $display("%0t: unexpected result duration %0d phase %0d extended %0b",
                         $time, next_duration_ms, phase, extended);
                errors++;
            end
            else
            begin
                want = pending_timings.pop_front();
                if (next_duration_ms !== want.duration)
                begin
                    $display("%0t: next_duration_ms expected %0d actual %0d", $time,
                             want.duration, next_duration_ms);
                    errors++;
                end
                if (phase !== want.phase)
                begin
                    $display("%0t: phase expected %0d actual %0d", $time, want.phase, phase);
                    errors++;
                end
                if (extended !== want.extended)
                begin
                    $display("%0t: extended expected %0b actual %0b", $time, want.extended,
                             extended);
                    errors++;
                end
            end
            sink_wait = snk_idle ? $urandom_range(0, IDLE_MAX) : 0;
        end
    end

    // Test sequence
    initial
    begin
        errors = 0;
        items_accepted = 0;
        switches_sent = 0;
        extensions = 0;
        advances = 0;
        regs_written = 0;
        results_seen = 0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        sink_wait = 0;
        stall_hold = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_NONE;
        index = '0;
        min_dur_ms = '0;
        max_dur_ms = '0;
        green = 1'b0;
        detector_mask = '0;
        gap_ms = '0;
        now_ms = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_MAX_GAP;
        cfg_data = '0;
        for (int d = 0; d < 16; d++)
            detector_age[d] = GAP_NONE;
        active_phase = '0;
        phase_begin_ms = '0;
        gap_limit_ms = MAX_GAP_RST;
        travel_ms = DET_GAP_RST;
        phases_in_use = PHASE_COUNT_RST;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_load();
        test_special_cases();
        test_random_settings();
        test_output_stall();
        test_sender_pause();

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d items in, %0d switch requests, %0d results (%0d extended, %0d advanced)",
                 items_accepted, switches_sent, results_seen, extensions, advances);
        $display("%0d register writes across gap and phase count settings, %0d cycles",
                 regs_written, cycle_count);
        if (errors == 0)
            $display("actuated_signal_gap_control_tb: clean");
        else
            $display("actuated_signal_gap_control_tb: errors");
        $finish;
    end

endmodule
